FILE: rtl/core/nau_pkg.sv
// Shared types, constants and helpers for the neural activation unit.
// No dependencies; used by nau_horner_step and neural_activation_unit.
`timescale 1ns / 1ps
`default_nettype none

package nau_pkg;

    // Register indexes on the configuration port
    localparam logic CFG_KIND = 1'b0;
    localparam logic CFG_DIR  = 1'b1;

    // activation_kind codes
    localparam logic [1:0] KIND_RELU    = 2'd0;
    localparam logic [1:0] KIND_CLIP    = 2'd1;
    localparam logic [1:0] KIND_SIGMOID = 2'd2;
    localparam logic [1:0] KIND_PASS    = 2'd3;

    // direction codes
    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_BWD = 1'b1;

    // Sigmoid regions by |x|
    localparam logic [1:0] REGION_INNER = 2'd0;
    localparam logic [1:0] REGION_CUBIC = 2'd1;
    localparam logic [1:0] REGION_OUTER = 2'd2;

    localparam int ACC_W = 34;   // Horner accumulator, Q32
    localparam int XX_W  = 23;   // x*x in Q16.16, nonnegative
    localparam int SUM_W = 36;   // final Q32 sum before rounding
    localparam int NSTEP = 5;    // Horner steps on x*x

    localparam logic signed [31:0] Q_ONE           = 32'sd65536;
    localparam logic signed [32:0] SIG_OUTER_LIMIT = 33'sd571058;   // 8.713655
    localparam logic signed [32:0] SIG_INNER_LIMIT = 33'sd294912;   // 4.5

    // Horner coefficients, Q32, leading term first. The cubic is padded
    // with leading zeros so both polynomials share the same step count.
    localparam logic signed [ACC_W-1:0] COEF_INNER [NSTEP+1] = '{
        -34'sd215, 34'sd15462, -34'sd456168, 34'sd7533802,
        -34'sd87860428, 34'sd1073352528
    };
    localparam logic signed [ACC_W-1:0] COEF_CUBIC [NSTEP+1] = '{
        34'sd0, 34'sd0, 34'sd0, 34'sd1374, -34'sd366962, 34'sd42944047
    };

    localparam logic signed [SUM_W-1:0] OFF_INNER    = 36'sd2147419223;
    localparam logic signed [SUM_W-1:0] OFF_CUBIC_POS = 36'sd4093778143;
    localparam logic signed [SUM_W-1:0] OFF_CUBIC_NEG = 36'sd201189153;
    localparam logic signed [SUM_W-1:0] ROUND_HALF    = 36'sd32768;

    typedef struct packed {
        logic [1:0]               kind;
        logic                     dir;
        logic signed [31:0]       x;
        logic signed [31:0]       a;
        logic signed [31:0]       g;
        logic                     last;
        logic [1:0]               region;
        logic [41:0]              sq;      // x*x, Q32
        logic signed [64:0]       dp;      // a*(1-a), Q32
        logic [XX_W-1:0]          xx;
        logic signed [31:0]       d16;
        logic signed [ACC_W-1:0]  acc;
        logic signed [57:0]       prod;
        logic signed [63:0]       gprod;
        logic signed [SUM_W-1:0]  sum;
        logic signed [31:0]       gres;
    } item_t;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -65'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nau_horner_step.sv
// One Horner step acc = floor(acc*xx / 2^16) + c as a two-stage pipeline.
// Depends on nau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nau_horner_step (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire nau_pkg::item_t                  in_item,
    input  wire logic signed [nau_pkg::ACC_W-1:0] coef_inner,
    input  wire logic signed [nau_pkg::ACC_W-1:0] coef_cubic,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output nau_pkg::item_t                       out_item
);

    logic            mul_valid_reg;
    logic            add_valid_reg;
    nau_pkg::item_t  mul_reg;
    nau_pkg::item_t  add_reg;
    nau_pkg::item_t  mul_next;
    nau_pkg::item_t  add_next;
    logic            mul_ready;
    logic            add_ready;
    logic signed [nau_pkg::ACC_W-1:0] coef;

    assign add_ready = !add_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || add_ready;
    assign in_ready  = mul_ready;
    assign out_valid = add_valid_reg;
    assign out_item  = add_reg;

    // multiply stage
    always_comb begin
        mul_next      = in_item;
        mul_next.prod = in_item.acc * $signed({1'b0, in_item.xx});
    end

    // shift and add stage
    always_comb begin
        coef = (mul_reg.region == nau_pkg::REGION_CUBIC) ? coef_cubic : coef_inner;
        add_next     = mul_reg;
        add_next.acc = nau_pkg::ACC_W'(mul_reg.prod >>> 16) + coef;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
        end else begin
            if (mul_ready) begin
                mul_valid_reg <= in_valid;
            end
            if (add_ready) begin
                add_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && in_valid) begin
            mul_reg <= mul_next;
        end
        if (add_ready && mul_valid_reg) begin
            add_reg <= add_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/neural_activation_unit.sv
// Top level of the element-wise activation unit: config registers and pipeline.
// Depends on nau_pkg and nau_horner_step.
`timescale 1ns / 1ps
`default_nettype none

// Streams one element per cycle. Each transfer carries x, a and g in signed
// Q16.16; the configured kind and direction pick ReLU, clipped ReLU or a
// piecewise polynomial sigmoid, forward or backward, and one result transfer
// comes out per input transfer, in order. The datapath is a 16-stage
// pipeline: input/region stage, x*x and a*(1-a) multiplies, scaling, five
// Horner steps of two stages each, the final multiply by x and g*d16,
// rounding/saturation, and the output register. Every multiplier is
// registered, so a new element is taken in every cycle; throughput is one
// transfer per cycle whenever m_ready is high. Each stage holds its item
// until the next one frees up, so a stall on the result side backs up
// stage by stage and s_ready drops only when all stages are full. Kind and
// direction travel with each element, so results follow the setting in
// effect when the element was taken. Configuration writes have no handshake;
// write them with the unit idle.

module neural_activation_unit (
    input  wire                 aclk,
    input  wire                 aresetn,
    // configuration
    input  wire                 cfg_wr_en,
    input  wire                 cfg_addr,
    input  wire  [1:0]          cfg_wdata,
    // input channel
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  signed [31:0]  s_pre_activation,
    input  wire  signed [31:0]  s_activated_value,
    input  wire  signed [31:0]  s_gradient_in,
    input  wire                 s_last_element,
    // result channel
    output logic                m_valid,
    input  wire                 m_ready,
    output logic signed [31:0]  m_result_value,
    output logic                m_last_out
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0] kind_reg;
    logic       dir_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= nau_pkg::KIND_RELU;
            dir_reg  <= nau_pkg::DIR_FWD;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                nau_pkg::CFG_KIND: begin
                    kind_reg <= cfg_wdata;
                end
                nau_pkg::CFG_DIR: begin
                    dir_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage registers and handshake
    // ------------------------------------------------------------------
    logic           s0_valid_reg, s1_valid_reg, s2_valid_reg;
    logic           f1_valid_reg, f2_valid_reg, f3_valid_reg;
    nau_pkg::item_t s0_reg, s1_reg, s2_reg, f1_reg, f2_reg, f3_reg;
    nau_pkg::item_t s0_next, s1_next, s2_next, f1_next, f2_next, f3_next;
    logic           s0_ready, s1_ready, s2_ready, f1_ready, f2_ready, f3_ready;

    logic           h_valid [nau_pkg::NSTEP+1];
    logic           h_ready [nau_pkg::NSTEP+1];
    nau_pkg::item_t h_item  [nau_pkg::NSTEP+1];

    assign f3_ready = !f3_valid_reg || m_ready;
    assign f2_ready = !f2_valid_reg || f3_ready;
    assign f1_ready = !f1_valid_reg || f2_ready;
    assign s2_ready = !s2_valid_reg || h_ready[0];
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign s_ready  = s0_ready;

    assign h_valid[0]              = s2_valid_reg;
    assign h_item[0]               = s2_reg;
    assign h_ready[nau_pkg::NSTEP] = f1_ready;

    assign m_valid        = f3_valid_reg;
    assign m_result_value = f3_reg.gres;
    assign m_last_out     = f3_reg.last;

    // ------------------------------------------------------------------
    // S0: capture, sigmoid region from |x|
    // ------------------------------------------------------------------
    logic signed [32:0] abs_x;

    always_comb begin
        abs_x = s_pre_activation[31] ? (33'sd0 - 33'(s_pre_activation))
                                     : 33'(s_pre_activation);
        s0_next        = '0;
        s0_next.kind   = kind_reg;
        s0_next.dir    = dir_reg;
        s0_next.x      = s_pre_activation;
        s0_next.a      = s_activated_value;
        s0_next.g      = s_gradient_in;
        s0_next.last   = s_last_element;
        if (abs_x > nau_pkg::SIG_OUTER_LIMIT) begin
            s0_next.region = nau_pkg::REGION_OUTER;
        end else if (abs_x > nau_pkg::SIG_INNER_LIMIT) begin
            s0_next.region = nau_pkg::REGION_CUBIC;
        end else begin
            s0_next.region = nau_pkg::REGION_INNER;
        end
    end

    // ------------------------------------------------------------------
    // S1: x*x (x fits in 21 bits wherever the sigmoid uses it), a*(1-a)
    // ------------------------------------------------------------------
    logic signed [32:0] one_minus_a;
    logic signed [41:0] sq_s;

    always_comb begin
        one_minus_a = 33'sd65536 - 33'(s0_reg.a);
        sq_s        = $signed(s0_reg.x[20:0]) * $signed(s0_reg.x[20:0]);
        s1_next     = s0_reg;
        s1_next.sq  = sq_s;
        s1_next.dp  = s0_reg.a * one_minus_a;
    end

    // ------------------------------------------------------------------
    // S2: scale to Q16.16, seed Horner accumulator
    // ------------------------------------------------------------------
    always_comb begin
        s2_next     = s1_reg;
        s2_next.xx  = s1_reg.sq[nau_pkg::XX_W+15:16];
        s2_next.d16 = nau_pkg::sat32(s1_reg.dp >>> 16);
        s2_next.acc = (s1_reg.region == nau_pkg::REGION_CUBIC) ? nau_pkg::COEF_CUBIC[0]
                                                               : nau_pkg::COEF_INNER[0];
    end

    // ------------------------------------------------------------------
    // Horner steps on x*x, coefficients one through five
    // ------------------------------------------------------------------
    for (genvar i = 0; i < nau_pkg::NSTEP; i++) begin : g_step
        nau_horner_step u_step (
            .aclk (aclk), .aresetn (aresetn),
            .in_valid (h_valid[i]), .in_ready (h_ready[i]), .in_item (h_item[i]),
            .coef_inner (nau_pkg::COEF_INNER[i+1]),
            .coef_cubic (nau_pkg::COEF_CUBIC[i+1]),
            .out_valid (h_valid[i+1]), .out_ready (h_ready[i+1]),
            .out_item (h_item[i+1])
        );
    end

    // ------------------------------------------------------------------
    // F1: acc*x for the odd polynomial, g*d16 for sigmoid backward
    // ------------------------------------------------------------------
    always_comb begin
        f1_next       = h_item[nau_pkg::NSTEP];
        f1_next.prod  = h_item[nau_pkg::NSTEP].acc * $signed(h_item[nau_pkg::NSTEP].x[20:0]);
        f1_next.gprod = h_item[nau_pkg::NSTEP].g * h_item[nau_pkg::NSTEP].d16;
    end

    // ------------------------------------------------------------------
    // F2: add offset and rounding half, saturate gradient product
    // ------------------------------------------------------------------
    logic signed [nau_pkg::SUM_W-1:0] offset;

    always_comb begin
        if (f1_reg.region == nau_pkg::REGION_CUBIC) begin
            offset = (f1_reg.x > 32'sd0) ? nau_pkg::OFF_CUBIC_POS : nau_pkg::OFF_CUBIC_NEG;
        end else begin
            offset = nau_pkg::OFF_INNER;
        end
        f2_next      = f1_reg;
        f2_next.sum  = nau_pkg::SUM_W'(f1_reg.prod >>> 16) + offset + nau_pkg::ROUND_HALF;
        f2_next.gres = nau_pkg::sat32(65'(f1_reg.gprod >>> 16));
    end

    // ------------------------------------------------------------------
    // F3: result select into the output register (gres carries the result)
    // ------------------------------------------------------------------
    logic signed [nau_pkg::SUM_W-1:0] sig_r;
    logic signed [31:0]               sig_val;
    logic signed [31:0]               res;
    logic                             x_neg;
    logic                             x_gt_one;
    logic                             x_pos;

    always_comb begin
        sig_r    = f2_reg.sum >>> 16;
        x_neg    = f2_reg.x[31];
        x_pos    = !f2_reg.x[31] && (f2_reg.x != 32'sd0);
        x_gt_one = f2_reg.x > nau_pkg::Q_ONE;
        if (f2_reg.region == nau_pkg::REGION_OUTER) begin
            sig_val = x_pos ? nau_pkg::Q_ONE : 32'sd0;
        end else if (sig_r < 0) begin
            sig_val = 32'sd0;
        end else if (sig_r > nau_pkg::SUM_W'(nau_pkg::Q_ONE)) begin
            sig_val = nau_pkg::Q_ONE;
        end else begin
            sig_val = sig_r[31:0];
        end

        if (f2_reg.dir == nau_pkg::DIR_FWD) begin
            case (f2_reg.kind)
                nau_pkg::KIND_RELU:    res = x_neg ? 32'sd0 : f2_reg.x;
                nau_pkg::KIND_CLIP:    res = x_neg ? 32'sd0
                                           : (x_gt_one ? nau_pkg::Q_ONE : f2_reg.x);
                nau_pkg::KIND_SIGMOID: res = sig_val;
                default:               res = f2_reg.x;
            endcase
        end else begin
            case (f2_reg.kind)
                nau_pkg::KIND_RELU:    res = x_neg ? 32'sd0 : f2_reg.g;
                nau_pkg::KIND_CLIP:    res = (x_pos && (f2_reg.x < nau_pkg::Q_ONE))
                                           ? f2_reg.g : 32'sd0;
                nau_pkg::KIND_SIGMOID: res = f2_reg.gres;
                default:               res = f2_reg.g;
            endcase
        end
        f3_next      = f2_reg;
        f3_next.gres = res;
    end

    // ------------------------------------------------------------------
    // Valid bits and payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end else begin
            if (s0_ready) s0_valid_reg <= s_valid;
            if (s1_ready) s1_valid_reg <= s0_valid_reg;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (f1_ready) f1_valid_reg <= h_valid[nau_pkg::NSTEP];
            if (f2_ready) f2_valid_reg <= f1_valid_reg;
            if (f3_ready) f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s0_ready && s_valid)                 s0_reg <= s0_next;
        if (s1_ready && s0_valid_reg)            s1_reg <= s1_next;
        if (s2_ready && s1_valid_reg)            s2_reg <= s2_next;
        if (f1_ready && h_valid[nau_pkg::NSTEP]) f1_reg <= f1_next;
        if (f2_ready && f1_valid_reg)            f2_reg <= f2_next;
        if (f3_ready && f2_valid_reg)            f3_reg <= f3_next;
    end

`ifndef SYNTHESIS
    // sigmoid forward output stays within [0, 1]
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && f3_reg.kind == nau_pkg::KIND_SIGMOID && f3_reg.dir == nau_pkg::DIR_FWD)
        |-> (m_result_value >= 32'sd0 && m_result_value <= nau_pkg::Q_ONE))
        else $error("sigmoid forward result out of [0,1]");

    // ReLU forward never yields a negative value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && f3_reg.kind == nau_pkg::KIND_RELU && f3_reg.dir == nau_pkg::DIR_FWD)
        |-> !m_result_value[31])
        else $error("relu forward result negative");

    // ReLU backward zeroes the gradient for negative x
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && f3_reg.kind == nau_pkg::KIND_RELU && f3_reg.dir == nau_pkg::DIR_BWD
         && f3_reg.x[31]) |-> (m_result_value == 32'sd0))
        else $error("relu backward gradient not masked");

    // an item held in a stalled stage is not dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        (f2_valid_reg && !f3_ready) |=> f2_valid_reg)
        else $error("item lost from stalled stage");

    // the input side takes a transfer only when the first stage can hold it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s0_valid_reg)
        else $error("accepted transfer not captured");
`endif

endmodule

`default_nettype wire
